// ===== hw/rtl/pgpm_pkg.sv =====
// types, codes and constants shared by the gamepad poll master
// no dependencies

package pgpm_pkg;

    localparam int POLL_BYTES  = 5;
    localparam int LINE_W      = 8;
    localparam int INDEX_W     = 3;
    localparam int BUTTONS_W   = 16;
    localparam int COUNT_W     = 4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_CONTROLLERS = 1'b1;

    localparam logic [2:0] BYTE_LOW_REPORT  = 3'd3;
    localparam logic [2:0] BYTE_LAST        = 3'd4;
    localparam logic [2:0] BIT_LAST         = 3'd7;

    localparam logic [7:0]         HALF_PERIOD_RESET = 8'd10;
    localparam logic [COUNT_W-1:0] CONTROLLERS_RESET = 4'd1;

    typedef struct packed {
        logic              op;
        logic [LINE_W-1:0] data_lines;
    } req_t;

    typedef struct packed {
        logic                 clock_level;
        logic                 command_level;
        logic                 attention_level;
        logic                 busy_res;
        logic                 report_valid;
        logic [INDEX_W-1:0]   controller_index;
        logic [BUTTONS_W-1:0] buttons;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic clock_level;
        logic command_level;
        logic attention_level;
        logic busy_res;
    } line_state_t;

    localparam line_state_t LINES_IDLE = '{
        clock_level: 1'b1, command_level: 1'b1, attention_level: 1'b1, busy_res: 1'b0
    };

    typedef struct packed {
        logic clear;
        logic shift;
        logic to_high;
    } lane_ctl_t;

    typedef enum logic {
        EMIT_IDLE,
        EMIT_REPORTS
    } emit_state_t;

    function automatic logic [7:0] cmd_byte(input logic [2:0] byte_number);
        logic [7:0] value;
        unique case (byte_number)
            3'd0:    value = 8'h01;
            3'd1:    value = 8'h42;
            default: value = 8'hFF;
        endcase
        return value;
    endfunction

endpackage

// ===== hw/rtl/pgpm_lane.sv =====
// one controller's report shift register
// uses pgpm_pkg

module pgpm_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pgpm_pkg::lane_ctl_t                ctl,
    input  logic                               enable,
    input  logic                               data_line,
    output logic [pgpm_pkg::BUTTONS_W-1:0]     buttons
);

    logic [7:0] low_reg;
    logic [7:0] low_next;
    logic [7:0] high_reg;
    logic [7:0] high_next;
    logic       sample_bit;

    assign sample_bit = ~data_line;

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (ctl.clear)
        begin
            low_next  = '0;
            high_next = '0;
        end
        else if (ctl.shift && enable)
        begin
            if (ctl.to_high)
            begin
                high_next = {high_reg[6:0], sample_bit};
            end
            else
            begin
                low_next = {low_reg[6:0], sample_bit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign buttons = {high_reg, low_reg};

endmodule

// ===== hw/rtl/pgpm_seq.sv =====
// bit and byte sequencer: tick counter, clock phase, command byte
// uses pgpm_pkg

module pgpm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          op,
    input  logic [7:0]                    half_period,
    output pgpm_pkg::lane_ctl_t           lane_ctl,
    output pgpm_pkg::line_state_t         lines,
    output logic                          done
);

    logic       active_reg, active_next;
    logic [2:0] byte_reg, byte_next;
    logic [2:0] bit_reg, bit_next;
    logic       phase_low_reg, phase_low_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] period;

    assign period = (half_period == 8'd0) ? 8'd1 : half_period;

    always_comb
    begin
        active_next    = active_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        phase_low_next = phase_low_reg;
        tick_next      = tick_reg;
        cmd_next       = cmd_reg;
        lane_ctl       = '0;
        done           = 1'b0;
        if (step)
        begin
            if (op == pgpm_pkg::OP_START)
            begin
                if (!active_reg)
                begin
                    active_next    = 1'b1;
                    byte_next      = '0;
                    bit_next       = '0;
                    phase_low_next = 1'b1;
                    tick_next      = '0;
                    cmd_next       = pgpm_pkg::cmd_byte(3'd0);
                end
            end
            else if (active_reg)
            begin
                tick_next = tick_reg + 8'd1;
                if (tick_next >= period)
                begin
                    tick_next = '0;
                    priority if (phase_low_reg)
                    begin
                        lane_ctl.shift   = (byte_reg >= pgpm_pkg::BYTE_LOW_REPORT);
                        lane_ctl.to_high = (byte_reg != pgpm_pkg::BYTE_LOW_REPORT);
                        phase_low_next   = 1'b0;
                    end
                    else if (bit_reg != pgpm_pkg::BIT_LAST)
                    begin
                        bit_next       = bit_reg + 3'd1;
                        phase_low_next = 1'b1;
                    end
                    else if (byte_reg != pgpm_pkg::BYTE_LAST)
                    begin
                        byte_next      = byte_reg + 3'd1;
                        bit_next       = '0;
                        cmd_next       = pgpm_pkg::cmd_byte(byte_next);
                        lane_ctl.clear = (byte_next == pgpm_pkg::BYTE_LOW_REPORT);
                        phase_low_next = 1'b1;
                    end
                    else
                    begin
                        active_next    = 1'b0;
                        byte_next      = '0;
                        bit_next       = '0;
                        phase_low_next = 1'b0;
                        done           = 1'b1;
                    end
                end
            end
        end
    end

    // line levels as they stand after this request
    always_comb
    begin
        lines.clock_level     = active_next ? ~phase_low_next : 1'b1;
        lines.command_level   = active_next ? cmd_next[bit_next] : 1'b1;
        lines.attention_level = ~active_next;
        lines.busy_res        = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            byte_reg      <= '0;
            bit_reg       <= '0;
            phase_low_reg <= 1'b0;
            tick_reg      <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            byte_reg      <= byte_next;
            bit_reg       <= bit_next;
            phase_low_reg <= phase_low_next;
            tick_reg      <= tick_next;
            cmd_reg       <= cmd_next;
        end
    end

endmodule

// ===== hw/rtl/pgpm_merge.sv =====
// merges lane reports into the result stream, holds the output register
// uses pgpm_pkg

module pgpm_merge #(
    parameter int MAX_CONTROLLERS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  pgpm_pkg::line_state_t                  lines,
    input  logic                                   done,
    input  logic [pgpm_pkg::COUNT_W-1:0]           used,
    input  logic [pgpm_pkg::BUTTONS_W-1:0]         lane_buttons [MAX_CONTROLLERS],
    output logic                                   step_ready,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output pgpm_pkg::res_t                         res_data
);

    pgpm_pkg::emit_state_t             state_reg, state_next;
    logic [pgpm_pkg::INDEX_W-1:0]      idx_reg, idx_next;
    logic [pgpm_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                              valid_reg, valid_next;
    pgpm_pkg::res_t                    data_reg, data_next;
    logic                              out_free;
    logic [pgpm_pkg::INDEX_W-1:0]      sel_idx;
    logic [pgpm_pkg::BUTTONS_W-1:0]    sel_buttons;
    logic                              sel_last;

    assign out_free   = !valid_reg || res_ready;
    assign step_ready = (state_reg == pgpm_pkg::EMIT_IDLE) && out_free;

    assign sel_idx  = (state_reg == pgpm_pkg::EMIT_IDLE) ? '0 : idx_reg;
    assign sel_last = ({1'b0, sel_idx} + 4'd1) ==
                      ((state_reg == pgpm_pkg::EMIT_IDLE) ? used : count_reg);

    always_comb
    begin
        sel_buttons = '0;
        for (int j = 0; j < MAX_CONTROLLERS; j++)
        begin
            if (pgpm_pkg::INDEX_W'(j) == sel_idx)
            begin
                sel_buttons = lane_buttons[j];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        unique case (state_reg)
            pgpm_pkg::EMIT_IDLE:
            begin
                if (step && done && used != '0 && !sel_last)
                begin
                    state_next = pgpm_pkg::EMIT_REPORTS;
                    idx_next   = pgpm_pkg::INDEX_W'(1);
                    count_next = used;
                end
            end
            pgpm_pkg::EMIT_REPORTS:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + pgpm_pkg::INDEX_W'(1);
                    if (sel_last)
                    begin
                        state_next = pgpm_pkg::EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pgpm_pkg::EMIT_IDLE;
            end
        endcase
    end

    // output register load
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = 1'b0;
        end
        priority if ((state_reg == pgpm_pkg::EMIT_REPORTS && out_free) ||
                     (step && done && used != '0))
        begin
            valid_next                = 1'b1;
            data_next.clock_level     = pgpm_pkg::LINES_IDLE.clock_level;
            data_next.command_level   = pgpm_pkg::LINES_IDLE.command_level;
            data_next.attention_level = pgpm_pkg::LINES_IDLE.attention_level;
            data_next.busy_res        = pgpm_pkg::LINES_IDLE.busy_res;
            data_next.report_valid    = 1'b1;
            data_next.controller_index = sel_idx;
            data_next.buttons         = sel_buttons;
            data_next.last            = sel_last;
        end
        else if (step)
        begin
            valid_next                = 1'b1;
            data_next.clock_level     = lines.clock_level;
            data_next.command_level   = lines.command_level;
            data_next.attention_level = lines.attention_level;
            data_next.busy_res        = lines.busy_res;
            data_next.report_valid    = 1'b0;
            data_next.controller_index = '0;
            data_next.buttons         = '0;
            data_next.last            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgpm_pkg::EMIT_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// ===== hw/rtl/parallel_gamepad_poll_master_core.sv =====
// top level of the gamepad poll master: config registers, sequencer, lanes, merge
// uses pgpm_pkg, pgpm_seq, pgpm_lane, pgpm_merge
//
// channel   valid      ready      payload
// request   req_valid  req_ready  req_data  (op, data_lines)
// result    res_valid  res_ready  res_data  (line levels, report fields, last)
// config    cfg_write  -          cfg_index, cfg_data
//
// one request per cycle while req_ready is high; the tick that ends a poll gives
// one report per controller in use, one per cycle unless res_ready stalls, and
// requests wait until the last is loaded; lane count is MAX_CONTROLLERS, and
// every lane in use samples on the same tick; reset clears control and lane state,
// not the result data register, no clearing pass; a stalled result holds off new requests

module parallel_gamepad_poll_master_core #(
    parameter int MAX_CONTROLLERS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pgpm_pkg::req_t      req_data,
    output logic                res_valid,
    input  logic                res_ready,
    output pgpm_pkg::res_t      res_data,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam logic [pgpm_pkg::COUNT_W-1:0] MAX_COUNT =
        pgpm_pkg::COUNT_W'(MAX_CONTROLLERS);

    logic [7:0]                       half_period_reg;
    logic [pgpm_pkg::COUNT_W-1:0]     controllers_reg;
    logic [pgpm_pkg::COUNT_W-1:0]     used;
    logic                             step;
    pgpm_pkg::lane_ctl_t              lane_ctl;
    pgpm_pkg::line_state_t            lines;
    logic                             done;
    logic [pgpm_pkg::BUTTONS_W-1:0]   lane_buttons [MAX_CONTROLLERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= pgpm_pkg::HALF_PERIOD_RESET;
            controllers_reg <= pgpm_pkg::CONTROLLERS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pgpm_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                pgpm_pkg::CFG_CONTROLLERS:
                    controllers_reg <= cfg_data[pgpm_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign used = (controllers_reg > MAX_COUNT) ? MAX_COUNT : controllers_reg;
    assign step = req_valid && req_ready;

    pgpm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .op          (req_data.op),
        .half_period (half_period_reg),
        .lane_ctl    (lane_ctl),
        .lines       (lines),
        .done        (done)
    );

    for (genvar j = 0; j < MAX_CONTROLLERS; j++)
    begin : g_lane
        pgpm_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl),
            .enable    (pgpm_pkg::COUNT_W'(j) < used),
            .data_line (req_data.data_lines[j]),
            .buttons   (lane_buttons[j])
        );
    end

    pgpm_merge #(
        .MAX_CONTROLLERS (MAX_CONTROLLERS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .lines        (lines),
        .done         (done),
        .used         (used),
        .lane_buttons (lane_buttons),
        .step_ready   (req_ready),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_data     (res_data)
    );

    a_no_request_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.report_valid && !res_data.last |-> !req_ready)
        else $error("request taken while reports still pending");

    a_report_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.report_valid |->
            res_data.attention_level && !res_data.busy_res && res_data.clock_level)
        else $error("report carries active bus levels");

    a_report_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.report_valid |->
            pgpm_pkg::COUNT_W'(res_data.controller_index) < used)
        else $error("report index beyond controllers in use");

    a_busy_matches_attention: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.busy_res != res_data.attention_level)
        else $error("busy and attention disagree");

endmodule
